// ----- design/raster_hole_fill_idw_7x7_assert.svh -----
`ifndef RASTER_HOLE_FILL_IDW_7X7_ASSERT_SVH
`define RASTER_HOLE_FILL_IDW_7X7_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RHF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rhf check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define RHF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rhf check failed");

`endif

// ----- design/rhf_pkg.sv -----
`timescale 1ns / 1ps

package rhf_pkg;

    localparam int RADIUS        = 3;
    localparam int WIN           = 2 * RADIUS + 1;
    localparam int COLOR_BITS    = 16;
    localparam int MASK_BITS     = 8;
    localparam int LANES         = 3;
    localparam int WT_BITS       = 17;
    localparam int TOTAL_BITS    = 22;
    localparam int SUM_BITS      = TOTAL_BITS + COLOR_BITS;
    localparam int HEIGHT_BITS   = 14;
    localparam int OUT_ROW_BITS  = 13;
    localparam int MAX_HEIGHT    = 8192;
    localparam int IMAGE_RESET   = 2048;
    localparam int CFG_W_BITS    = 12;
    localparam int CFG_DATA_BITS = 14;
    localparam int D2_COUNT      = 2 * RADIUS * RADIUS + 1;

    localparam logic [MASK_BITS-1:0] MASK_SOLID = 8'hFF;

    typedef logic [0:0] cfg_index_t;
    localparam cfg_index_t REG_IMAGE_WIDTH  = 1'b0;
    localparam cfg_index_t REG_IMAGE_HEIGHT = 1'b1;

    typedef logic [2:0] tap_t;
    typedef logic [WT_BITS-1:0] weight_t;
    typedef logic [COLOR_BITS-1:0] color_t;

    // round(65536 / distance) by squared distance; the center tap is never summed
    localparam weight_t WEIGHT_TAB [D2_COUNT] = '{
        17'd0,     17'd65536, 17'd46341, 17'd0,     17'd32768, 17'd29309, 17'd0,
        17'd0,     17'd23170, 17'd21845, 17'd20724, 17'd0,     17'd0,     17'd18176,
        17'd0,     17'd0,     17'd0,     17'd0,     17'd15447
    };

    typedef struct packed {
        logic [COLOR_BITS-1:0] red_in;
        logic [COLOR_BITS-1:0] green_in;
        logic [COLOR_BITS-1:0] blue_in;
        logic [MASK_BITS-1:0]  mask_in;
        logic                  flush;
    } pix_t;

    typedef struct packed {
        logic [COLOR_BITS-1:0] red_out;
        logic [COLOR_BITS-1:0] green_out;
        logic [COLOR_BITS-1:0] blue_out;
        logic [MASK_BITS-1:0]  mask_out;
        logic                  was_filled;
        logic                  frame_last;
    } res_t;

    typedef struct packed {
        logic [MASK_BITS-1:0]     mask;
        color_t [LANES-1:0]       color;
    } cell_t;

    typedef struct packed {
        logic acc_clear;
        logic mul_en;
        logic div_load;
        logic div_step;
    } lane_ctrl_t;

    typedef struct packed {
        logic load;
        logic fill;
        logic last;
    } merge_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_TAIL,
        ST_LOAD,
        ST_DIV,
        ST_EMIT
    } state_t;

    function automatic weight_t tap_weight(tap_t dx, tap_t dy);
        logic [1:0] ax;
        logic [1:0] ay;
        logic [4:0] d2;
        ax = (dx > tap_t'(RADIUS)) ? 2'(dx - tap_t'(RADIUS)) : 2'(tap_t'(RADIUS) - dx);
        ay = (dy > tap_t'(RADIUS)) ? 2'(dy - tap_t'(RADIUS)) : 2'(tap_t'(RADIUS) - dy);
        d2 = 5'(ax) * 5'(ax) + 5'(ay) * 5'(ay);
        return WEIGHT_TAB[d2];
    endfunction

endpackage

// ----- design/rhf_store.sv -----
`timescale 1ns / 1ps

module rhf_store #(
    parameter int DEPTH = 14336,
    parameter int AW    = 14
) (
    input  logic           clk,
    input  logic           we,
    input  logic [AW-1:0]  waddr,
    input  rhf_pkg::cell_t wdata,
    input  logic [AW-1:0]  raddr,
    output rhf_pkg::cell_t rdata
);
    import rhf_pkg::*;

    cell_t mem [DEPTH];
    cell_t rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    assign rdata = rd_reg;

endmodule

// ----- design/rhf_lane.sv -----
`timescale 1ns / 1ps

module rhf_lane (
    input  logic                             clk,
    input  logic                             rst_n,
    input  rhf_pkg::lane_ctrl_t              ctrl,
    input  rhf_pkg::color_t                  color,
    input  rhf_pkg::weight_t                 weight,
    input  logic [rhf_pkg::TOTAL_BITS-1:0]   total,
    output rhf_pkg::color_t                  quotient
);
    import rhf_pkg::*;

    localparam int PROD_BITS = COLOR_BITS + WT_BITS;

    logic [PROD_BITS-1:0]  prod_reg;
    logic                  prod_vld_reg;
    logic [SUM_BITS-1:0]   sum_reg;
    logic [TOTAL_BITS-1:0] rem_reg;
    color_t                low_reg;
    color_t                quo_reg;
    logic [SUM_BITS-1:0]   dividend;
    logic [TOTAL_BITS:0]   trial;
    logic                  take;

    // rounding half up: add half the weight total before dividing
    assign dividend = sum_reg + SUM_BITS'(total >> 1);
    assign trial    = {rem_reg, low_reg[COLOR_BITS-1]};
    assign take     = (trial >= {1'b0, total});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctrl.mul_en;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_BITS'(color) * PROD_BITS'(weight);
        if (ctrl.acc_clear)
        begin
            sum_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            sum_reg <= sum_reg + SUM_BITS'(prod_reg);
        end
        if (ctrl.div_load)
        begin
            rem_reg <= dividend[SUM_BITS-1 -: TOTAL_BITS];
            low_reg <= dividend[COLOR_BITS-1:0];
            quo_reg <= '0;
        end
        else if (ctrl.div_step)
        begin
            rem_reg <= take ? TOTAL_BITS'(trial - {1'b0, total}) : trial[TOTAL_BITS-1:0];
            low_reg <= {low_reg[COLOR_BITS-2:0], 1'b0};
            quo_reg <= {quo_reg[COLOR_BITS-2:0], take};
        end
    end

    assign quotient = quo_reg;

endmodule

// ----- design/rhf_merge.sv -----
`timescale 1ns / 1ps

module rhf_merge (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  rhf_pkg::merge_ctrl_t                        ctrl,
    input  rhf_pkg::cell_t                              cur,
    input  rhf_pkg::color_t [rhf_pkg::LANES-1:0]        quotient,
    input  logic                                        res_stall,
    output logic                                        res_valid,
    output rhf_pkg::res_t                               res,
    output logic                                        free,
    output rhf_pkg::cell_t                              merged
);
    import rhf_pkg::*;

    logic res_valid_reg;
    logic res_valid_next;
    res_t res_reg;

    always_comb
    begin
        merged = cur;
        if (ctrl.fill)
        begin
            merged.mask  = MASK_SOLID;
            merged.color = quotient;
        end
    end

    assign free = !res_valid_reg || !res_stall;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (ctrl.load)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            res_reg <= '{red_out:    merged.color[0],
                         green_out:  merged.color[1],
                         blue_out:   merged.color[2],
                         mask_out:   merged.mask,
                         was_filled: ctrl.fill,
                         frame_last: ctrl.last};
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ----- design/raster_hole_fill_idw_7x7.sv -----
`timescale 1ns / 1ps
// channel  dir  handshake             beat payload
// pix      in   pix_valid, pix_stall  rhf_pkg::pix_t
// res      out  res_valid, res_stall  rhf_pkg::res_t
// wr       in   wr_en                 wr_index, wr_data
// a pixel beat that releases no result leaves the block idle and ready for the next beat
// a result passes through accept, the window reads on the line store read port, the
// pipeline tail, decide and emit; a fill adds the divider steps, one per quotient bit
// reset clears positions and loads register defaults only; the line store is never cleared
// a stalled result waits in the output register while the next pixel beat is taken

module raster_hole_fill_idw_7x7 #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 pix_valid,
    output logic                                 pix_stall,
    input  rhf_pkg::pix_t                        pix,
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output rhf_pkg::res_t                        res,
    input  logic                                 wr_en,
    input  rhf_pkg::cfg_index_t                  wr_index,
    input  logic [rhf_pkg::CFG_DATA_BITS-1:0]    wr_data
);
    import rhf_pkg::*;

    localparam int DEPTH       = WIN * MAX_WIDTH;
    localparam int AW          = $clog2(DEPTH);
    localparam int WW          = $clog2(MAX_WIDTH + 1);
    localparam int CW          = $clog2(MAX_WIDTH);
    localparam int LW          = $clog2(3 * MAX_WIDTH + 5);
    localparam int DIV_CW      = $clog2(COLOR_BITS);
    localparam int WIDTH_RESET = (MAX_WIDTH < IMAGE_RESET) ? MAX_WIDTH : IMAGE_RESET;

    state_t state_reg, state_next;

    logic [WW-1:0]           w_reg, w_cfg;
    logic [HEIGHT_BITS-1:0]  h_reg, h_cfg;
    logic [CW-1:0]           in_col_reg;
    logic [HEIGHT_BITS-1:0]  in_row_reg;
    logic [CW-1:0]           out_col_reg;
    logic [OUT_ROW_BITS-1:0] out_row_reg;
    logic [AW-1:0]           wr_addr_reg;
    logic [AW-1:0]           out_addr_reg;
    logic [LW-1:0]           lead_reg;
    tap_t                    dx_reg, dy_reg;
    logic [AW-1:0]           row_addr_reg;
    logic                    tail_reg;
    logic [DIV_CW-1:0]       div_cnt_reg;
    logic                    fill_reg;
    logic                    s1_vld_reg, s1_inb_reg, s1_center_reg;
    weight_t                 s1_wt_reg;
    logic [TOTAL_BITS-1:0]   total_reg;
    cell_t                   cur_reg;

    logic                    accept, in_done, store, in_col_last, in_done_new, emit_go;
    logic [LW-1:0]           lead_new, thr;
    logic                    out_col_last, out_last, emit_fire;
    logic [AW:0]             three_w, row_start_sum, row_step_sum, tap_sum;
    logic [AW-1:0]           row_start, row_step, tap_addr;
    logic [AW-1:0]           wr_addr_inc, out_addr_inc;
    logic [HEIGHT_BITS:0]    ry;
    logic [WW:0]             cx;
    logic                    tap_inb, tap_center, sweep_last, use_tap, fill_go, div_last;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    cell_t                   mem_wdata, rd_cell, merged;
    lane_ctrl_t              lane_ctrl;
    merge_ctrl_t             mctrl;
    logic                    out_free;
    color_t [LANES-1:0]      quotient;

    // register decode with the clamps of the width and height ranges
    always_comb
    begin
        w_cfg = WW'(MAX_WIDTH);
        if (wr_data[CFG_W_BITS-1:0] == '0)
        begin
            w_cfg = WW'(1);
        end
        else if (int'(wr_data[CFG_W_BITS-1:0]) <= MAX_WIDTH)
        begin
            w_cfg = WW'(wr_data[CFG_W_BITS-1:0]);
        end
        h_cfg = HEIGHT_BITS'(MAX_HEIGHT);
        if (wr_data == '0)
        begin
            h_cfg = HEIGHT_BITS'(1);
        end
        else if (int'(wr_data) <= MAX_HEIGHT)
        begin
            h_cfg = wr_data;
        end
    end

    assign accept      = pix_valid && !pix_stall;
    assign in_done     = (in_row_reg >= h_reg);
    assign store       = accept && !pix.flush && !in_done;
    assign in_col_last = (WW'(in_col_reg) + WW'(1) == w_reg);
    assign in_done_new = in_done ||
                         (store && in_col_last && (HEIGHT_BITS'(in_row_reg + 1'b1) >= h_reg));
    assign lead_new    = lead_reg + LW'(store);
    assign thr         = LW'({w_reg, 1'b0}) + LW'(w_reg) + LW'(RADIUS + 1);
    assign emit_go     = accept && (in_done_new || lead_new >= thr);

    assign wr_addr_inc  = (wr_addr_reg == AW'(DEPTH - 1)) ? '0 : wr_addr_reg + 1'b1;
    assign out_addr_inc = (out_addr_reg == AW'(DEPTH - 1)) ? '0 : out_addr_reg + 1'b1;
    assign out_col_last = (WW'(out_col_reg) + WW'(1) == w_reg);
    assign out_last     = (out_row_reg == OUT_ROW_BITS'(h_reg - 1'b1)) && out_col_last;

    // window addressing modulo the store depth
    assign three_w       = (AW+1)'({w_reg, 1'b0}) + (AW+1)'(w_reg);
    assign row_start_sum = ((AW+1)'(out_addr_reg) >= three_w)
                           ? (AW+1)'(out_addr_reg) - three_w
                           : (AW+1)'(out_addr_reg) + (AW+1)'(DEPTH) - three_w;
    assign row_start     = row_start_sum[AW-1:0];
    assign row_step_sum  = (AW+1)'(row_addr_reg) + (AW+1)'(w_reg);
    assign row_step      = (row_step_sum >= (AW+1)'(DEPTH))
                           ? AW'(row_step_sum - (AW+1)'(DEPTH)) : row_step_sum[AW-1:0];

    always_comb
    begin
        tap_sum = (AW+1)'(row_addr_reg) + (AW+1)'(dx_reg);
        if (tap_sum < (AW+1)'(RADIUS))
        begin
            tap_addr = AW'(tap_sum + (AW+1)'(DEPTH) - (AW+1)'(RADIUS));
        end
        else if (tap_sum - (AW+1)'(RADIUS) >= (AW+1)'(DEPTH))
        begin
            tap_addr = AW'(tap_sum - (AW+1)'(RADIUS) - (AW+1)'(DEPTH));
        end
        else
        begin
            tap_addr = AW'(tap_sum - (AW+1)'(RADIUS));
        end
    end

    assign ry         = (HEIGHT_BITS+1)'(out_row_reg) + (HEIGHT_BITS+1)'(dy_reg);
    assign cx         = (WW+1)'(out_col_reg) + (WW+1)'(dx_reg);
    assign tap_inb    = (ry >= (HEIGHT_BITS+1)'(RADIUS))
                        && (ry < (HEIGHT_BITS+1)'(h_reg) + (HEIGHT_BITS+1)'(RADIUS))
                        && (cx >= (WW+1)'(RADIUS))
                        && (cx < (WW+1)'(w_reg) + (WW+1)'(RADIUS));
    assign tap_center = (dx_reg == tap_t'(RADIUS)) && (dy_reg == tap_t'(RADIUS));
    assign sweep_last = (dx_reg == tap_t'(WIN - 1)) && (dy_reg == tap_t'(WIN - 1));

    assign use_tap  = s1_vld_reg && s1_inb_reg && !s1_center_reg && (rd_cell.mask == MASK_SOLID);
    assign fill_go  = (cur_reg.mask != MASK_SOLID) && (total_reg != '0);
    assign div_last = (div_cnt_reg == DIV_CW'(COLOR_BITS - 1));
    assign emit_fire = (state_reg == ST_EMIT) && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (emit_go) state_next = ST_SWEEP;
            ST_SWEEP: if (sweep_last) state_next = ST_TAIL;
            ST_TAIL:  if (tail_reg) state_next = ST_LOAD;
            ST_LOAD:  state_next = fill_go ? ST_DIV : ST_EMIT;
            ST_DIV:   if (div_last) state_next = ST_EMIT;
            ST_EMIT:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pix_stall          = 1'b1;
        lane_ctrl          = '0;
        lane_ctrl.mul_en   = use_tap;
        mctrl              = '0;
        mctrl.fill         = fill_reg;
        mctrl.last         = out_last;
        unique case (state_reg)
            ST_IDLE:
            begin
                pix_stall           = 1'b0;
                lane_ctrl.acc_clear = emit_go;
            end
            ST_SWEEP, ST_TAIL: ;
            ST_LOAD:  lane_ctrl.div_load = fill_go;
            ST_DIV:   lane_ctrl.div_step = 1'b1;
            ST_EMIT:  mctrl.load = out_free;
            default: ;
        endcase
    end

    always_comb
    begin
        mem_we    = store || (emit_fire && fill_reg);
        mem_waddr = store ? wr_addr_reg : out_addr_reg;
        mem_wdata = merged;
        if (store)
        begin
            mem_wdata.mask  = pix.mask_in;
            mem_wdata.color = {pix.blue_in, pix.green_in, pix.red_in};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            w_reg        <= WW'(WIDTH_RESET);
            h_reg        <= HEIGHT_BITS'(IMAGE_RESET);
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            wr_addr_reg  <= '0;
            out_addr_reg <= '0;
            lead_reg     <= '0;
            dx_reg       <= '0;
            dy_reg       <= '0;
            row_addr_reg <= '0;
            tail_reg     <= 1'b0;
            div_cnt_reg  <= '0;
            fill_reg     <= 1'b0;
            s1_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            s1_vld_reg <= (state_reg == ST_SWEEP);
            if (wr_en)
            begin
                unique case (wr_index)
                    REG_IMAGE_WIDTH:  w_reg <= w_cfg;
                    REG_IMAGE_HEIGHT: h_reg <= h_cfg;
                    default: ;
                endcase
                in_col_reg   <= '0;
                in_row_reg   <= '0;
                out_col_reg  <= '0;
                out_row_reg  <= '0;
                wr_addr_reg  <= '0;
                out_addr_reg <= '0;
                lead_reg     <= '0;
            end
            else if (emit_fire && out_last)
            begin
                in_col_reg   <= '0;
                in_row_reg   <= '0;
                out_col_reg  <= '0;
                out_row_reg  <= '0;
                wr_addr_reg  <= '0;
                out_addr_reg <= '0;
                lead_reg     <= '0;
            end
            else
            begin
                if (store)
                begin
                    wr_addr_reg <= wr_addr_inc;
                    lead_reg    <= lead_new;
                    if (in_col_last)
                    begin
                        in_col_reg <= '0;
                        in_row_reg <= HEIGHT_BITS'(in_row_reg + 1'b1);
                    end
                    else
                    begin
                        in_col_reg <= in_col_reg + 1'b1;
                    end
                end
                if (emit_fire)
                begin
                    out_addr_reg <= out_addr_inc;
                    lead_reg     <= lead_reg - 1'b1;
                    if (out_col_last)
                    begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + 1'b1;
                    end
                    else
                    begin
                        out_col_reg <= out_col_reg + 1'b1;
                    end
                end
            end
            if (emit_go)
            begin
                dx_reg       <= '0;
                dy_reg       <= '0;
                row_addr_reg <= row_start;
            end
            else if (state_reg == ST_SWEEP)
            begin
                if (dx_reg == tap_t'(WIN - 1))
                begin
                    dx_reg       <= '0;
                    dy_reg       <= dy_reg + 1'b1;
                    row_addr_reg <= row_step;
                end
                else
                begin
                    dx_reg <= dx_reg + 1'b1;
                end
            end
            tail_reg <= (state_reg == ST_TAIL) && !tail_reg;
            if (state_reg == ST_LOAD)
            begin
                fill_reg    <= fill_go;
                div_cnt_reg <= '0;
            end
            else if (state_reg == ST_DIV)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_inb_reg    <= tap_inb;
        s1_center_reg <= tap_center;
        s1_wt_reg     <= tap_weight(dx_reg, dy_reg);
        if (lane_ctrl.acc_clear)
        begin
            total_reg <= '0;
        end
        else if (use_tap)
        begin
            total_reg <= total_reg + TOTAL_BITS'(s1_wt_reg);
        end
        if (s1_vld_reg && s1_center_reg)
        begin
            cur_reg <= rd_cell;
        end
    end

    rhf_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (tap_addr),
        .rdata (rd_cell)
    );

    for (genvar c = 0; c < LANES; c++)
    begin : g_lane
        rhf_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (lane_ctrl),
            .color    (rd_cell.color[c]),
            .weight   (s1_wt_reg),
            .total    (total_reg),
            .quotient (quotient[c])
        );
    end

    rhf_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mctrl),
        .cur       (cur_reg),
        .quotient  (quotient),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .res       (res),
        .free      (out_free),
        .merged    (merged)
    );

endmodule

// ----- design/rhf_checker.sv -----
`timescale 1ns / 1ps
`include "raster_hole_fill_idw_7x7_assert.svh"

module rhf_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          pix_stall,
    input logic          res_valid,
    input logic          res_stall,
    input rhf_pkg::res_t res
);
    import rhf_pkg::*;

    `RHF_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))
    `RHF_ASSERT_SAME(a_fill_solid, res_valid && res.was_filled, res.mask_out == MASK_SOLID)
    `RHF_ASSERT_SAME(a_res_after_sweep, $rose(res_valid), $past(pix_stall))

endmodule

bind raster_hole_fill_idw_7x7 rhf_checker u_rhf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_stall (pix_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import rhf_pkg::*;

    localparam int STORE_DEPTH = 7 * 2048;
    localparam int SETTLE_CYCLES = 150;

    class fill_scoreboard;
        bit [55:0] cells [STORE_DEPTH];
        int unsigned width_reg;
        int unsigned height_reg;
        int unsigned in_col, in_row, out_col, out_row;
        res_t pending_px [$];
        int errors;

        function new();
            width_reg = 2048;
            height_reg = 2048;
            errors = 0;
            restart();
        endfunction

        function void restart();
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
        endfunction

        function void set_reg(cfg_index_t idx, int unsigned value);
            if (idx == REG_IMAGE_WIDTH)
                width_reg = value & 12'hFFF;
            else
                height_reg = value & 14'h3FFF;
            restart();
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0) return 1;
            return (width_reg > 2048) ? 2048 : width_reg;
        endfunction

        function int unsigned eff_height();
            if (height_reg == 0) return 1;
            return (height_reg > 8192) ? 8192 : height_reg;
        endfunction

        function int unsigned idw_weight(int d2);
            case (d2)
                1: return 65536;
                2: return 46341;
                4: return 32768;
                5: return 29309;
                8: return 23170;
                9: return 21845;
                10: return 20724;
                13: return 18176;
                18: return 15447;
                default: return 0;
            endcase
        endfunction

        function int unsigned cell_addr(longint unsigned row, longint unsigned col,
                                        int unsigned w);
            return (row * w + col) % STORE_DEPTH;
        endfunction

        function bit frame_idle();
            return in_col == 0 && in_row == 0 && out_col == 0 && out_row == 0;
        endfunction

        function void note_pixel(pix_t p);
            int unsigned w, h, a;
            longint unsigned in_lin, out_lin, total;
            longint unsigned sums [3];
            bit [55:0] cur, nb;
            int ny, nx, wt;
            res_t r;
            w = eff_width();
            h = eff_height();
            if (!p.flush && in_row < h) begin
                cells[cell_addr(in_row, in_col, w)] =
                    {p.mask_in, p.red_in, p.green_in, p.blue_in};
                in_col++;
                if (in_col >= w) begin
                    in_col = 0;
                    in_row++;
                end
            end
            in_lin = longint'(in_row) * w + in_col;
            out_lin = longint'(out_row) * w + out_col;
            if (!(in_row >= h || in_lin >= out_lin + 3 * w + 4))
                return;
            a = cell_addr(out_row, out_col, w);
            cur = cells[a];
            r = '0;
            if (cur[55:48] != 8'hFF) begin
                sums = '{0, 0, 0};
                total = 0;
                for (int dy = -3; dy <= 3; dy++) begin
                    for (int dx = -3; dx <= 3; dx++) begin
                        ny = int'(out_row) + dy;
                        nx = int'(out_col) + dx;
                        if (ny < 0 || ny >= int'(h) || nx < 0 || nx >= int'(w))
                            continue;
                        nb = cells[cell_addr(ny, nx, w)];
                        if (nb[55:48] != 8'hFF)
                            continue;
                        wt = idw_weight(dx * dx + dy * dy);
                        sums[0] += longint'(nb[47:32]) * wt;
                        sums[1] += longint'(nb[31:16]) * wt;
                        sums[2] += longint'(nb[15:0]) * wt;
                        total += wt;
                    end
                end
                if (total > 0) begin
                    cur[47:32] = 16'((sums[0] + total / 2) / total);
                    cur[31:16] = 16'((sums[1] + total / 2) / total);
                    cur[15:0] = 16'((sums[2] + total / 2) / total);
                    cur[55:48] = 8'hFF;
                    r.was_filled = 1'b1;
                    cells[a] = cur;
                end
            end
            r.red_out = cur[47:32];
            r.green_out = cur[31:16];
            r.blue_out = cur[15:0];
            r.mask_out = cur[55:48];
            r.frame_last = (out_lin == longint'(w) * h - 1);
            pending_px = {pending_px, r};
            if (r.frame_last) begin
                restart();
            end else begin
                out_col++;
                if (out_col >= w) begin
                    out_col = 0;
                    out_row++;
                end
            end
        endfunction

        function void cmp_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check(res_t got);
            res_t want;
            if (pending_px.size() == 0) begin
                $display("%0t unexpected result beat: expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_px.pop_front();
            cmp_field("red_out", want.red_out, got.red_out);
            cmp_field("green_out", want.green_out, got.green_out);
            cmp_field("blue_out", want.blue_out, got.blue_out);
            cmp_field("mask_out", want.mask_out, got.mask_out);
            cmp_field("was_filled", want.was_filled, got.was_filled);
            cmp_field("frame_last", want.frame_last, got.frame_last);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic pix_valid;
    logic pix_stall;
    pix_t pix;
    logic res_valid;
    logic res_stall;
    res_t res;
    logic wr_en;
    cfg_index_t wr_index;
    logic [CFG_DATA_BITS-1:0] wr_data;

    fill_scoreboard sb = new();
    bit long_hold;
    int burst_left;

    raster_hole_fill_idw_7x7 dut (
        .clk(clk),
        .rst_n(rst_n),
        .pix_valid(pix_valid),
        .pix_stall(pix_stall),
        .pix(pix),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res(res),
        .wr_en(wr_en),
        .wr_index(wr_index),
        .wr_data(wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #40ms;
        $display("testbench: FAIL");
        $finish;
    end

    // receiver: random stall pattern that changes per segment, plus a long hold
    initial
    begin
        int mode;
        int seg;
        int hold_cnt;
        res_stall = 1'b0;
        mode = 0;
        seg = 0;
        hold_cnt = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
                sb.check(res);
            if (long_hold && hold_cnt == 0)
                hold_cnt = 600;
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                if (hold_cnt == 0)
                    long_hold = 1'b0;
                res_stall <= 1'b1;
            end
            else
            begin
                if (seg == 0)
                begin
                    seg = $urandom_range(50, 300);
                    mode = $urandom_range(0, 3);
                end
                seg--;
                case (mode)
                    0: res_stall <= 1'b0;
                    1: res_stall <= ($urandom_range(0, 1) == 1);
                    2: res_stall <= ($urandom_range(0, 9) < 8);
                    default: res_stall <= ($urandom_range(0, 9) == 0);
                endcase
            end
        end
    end

    task automatic send_beat(pix_t p);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 3) != 0)
            begin
                pix_valid <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
        burst_left--;
        pix_valid <= 1'b1;
        pix <= p;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
        sb.note_pixel(p);
    endtask

    task automatic settle();
        pix_valid <= 1'b0;
        while (sb.pending_px.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, int unsigned value);
        settle();
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= value[CFG_DATA_BITS-1:0];
        @(posedge clk);
        sb.set_reg(idx, value[CFG_DATA_BITS-1:0]);
        wr_en <= 1'b0;
    endtask

    task automatic set_size(int unsigned w, int unsigned h);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
    endtask

    function automatic pix_t rand_pixel();
        pix_t p;
        int pick;
        p.red_in = 16'($urandom);
        p.green_in = 16'($urandom);
        p.blue_in = 16'($urandom);
        pick = $urandom_range(0, 9);
        if (pick < 6)
            p.mask_in = MASK_SOLID;
        else if (pick == 6)
            p.mask_in = 8'd0;
        else if (pick == 7)
            p.mask_in = 8'd254;
        else
            p.mask_in = 8'($urandom);
        p.flush = 1'b0;
        return p;
    endfunction

    function automatic pix_t flush_beat();
        pix_t p;
        p = rand_pixel();
        p.flush = 1'b1;
        return p;
    endfunction

    function automatic pix_t make_pixel(int unsigned v, logic [7:0] m);
        pix_t p;
        p.red_in = 16'(v);
        p.green_in = 16'(65535 - v);
        p.blue_in = 16'(v ^ 16'h5A5A);
        p.mask_in = m;
        p.flush = 1'b0;
        return p;
    endfunction

    // drain the tail with flushes, some pixels mixed in
    task automatic drain_frame();
        while (!sb.frame_idle())
        begin
            if ($urandom_range(0, 4) == 0)
                send_beat(rand_pixel());
            else
                send_beat(flush_beat());
        end
    endtask

    task automatic random_frame(int unsigned count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_beat(flush_beat());
            send_beat(rand_pixel());
        end
        drain_frame();
    endtask

    initial
    begin
        int unsigned w, h;
        int sent;
        int frames;
        rst_n = 1'b0;
        pix_valid = 1'b0;
        pix = '0;
        wr_en = 1'b0;
        wr_index = REG_IMAGE_WIDTH;
        wr_data = '0;
        long_hold = 1'b0;
        burst_left = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all holes, no colored neighbor
        set_size(3, 3);
        for (int i = 0; i < 9; i++)
            send_beat(make_pixel((i % 2) ? 65535 : 0, (i % 2) ? 8'd0 : 8'd254));
        drain_frame();
        // lone colored pixel in a field of holes, flush mid-frame ignored
        send_beat(make_pixel(65535, 8'd0));
        send_beat(flush_beat());
        send_beat(make_pixel(65535, MASK_SOLID));
        for (int i = 0; i < 7; i++)
            send_beat(make_pixel(0, 8'd0));
        send_beat(make_pixel(12345, 8'd0));
        send_beat(make_pixel(0, 8'd0));
        drain_frame();

        // size extremes
        set_size(0, 0);
        send_beat(make_pixel(65535, 8'd7));
        send_beat(make_pixel(0, MASK_SOLID));
        set_size(1, 16'h3FFF);
        for (int i = 0; i < 30; i++)
            send_beat(rand_pixel());
        set_size(2048, 8192);
        for (int i = 0; i < 20; i++)
            send_beat(rand_pixel());
        set_size(14'h3FFF, 1);
        for (int i = 0; i < 20; i++)
            send_beat(rand_pixel());
        set_size(64, 2);
        for (int i = 0; i < 128; i++)
            send_beat(rand_pixel());
        drain_frame();

        sent = 0;
        frames = 0;
        while (sent < 550)
        begin
            if (frames % 3 == 0)
            begin
                w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
                h = $urandom_range(1, 10);
                set_size(w, h);
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                settle();
            end
            if (frames == 4)
                long_hold = 1'b1;
            w = sb.eff_width();
            h = sb.eff_height();
            random_frame(w * h);
            sent += w * h;
            frames++;
        end

        settle();
        if (sb.errors == 0 && sb.pending_px.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
